### src/mpp_pkg.sv
package mpp_pkg;

  // Field widths
  localparam int POS_W    = 16;
  localparam int SLIDER_W = 8;
  localparam int GAIN_W   = 8;
  localparam int SPEED_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier: signed A x signed B
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int PROD_W  = 48;
  localparam int ACC_W   = 27;

  // Reciprocal constants
  // floor(x / 255) = (x * RECIP_255) >> 32 for x < 2^24
  localparam logic [MUL_B_W-1:0] RECIP_255   = MUL_B_W'(16843010);
  // floor(x / 100) = (x * RECIP_100_50) >> 23, floor(x / 50) = (x * RECIP_100_50) >> 22
  localparam logic [MUL_B_W-1:0] RECIP_100_50 = MUL_B_W'(83887);
  localparam logic [23:0]        CEIL_BIAS_255 = 24'd254;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  // Register reset values
  localparam logic [POS_W-1:0]   RST_MIN_POSITION = '0;
  localparam logic [POS_W-1:0]   RST_MAX_POSITION = '0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_P       = 8'd80;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I       = 8'd10;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D       = 8'd100;
  localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT  = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_POSITION = 3'd0,
    CFG_MAX_POSITION = 3'd1,
    CFG_GAIN_P       = 3'd2,
    CFG_GAIN_I       = 3'd3,
    CFG_GAIN_D       = 3'd4,
    CFG_SPEED_LIMIT  = 3'd5
  } mpp_cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]   min_position;
    logic [POS_W-1:0]   max_position;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] speed_limit;
  } mpp_cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SPAN,
    OP_DIV255,
    OP_DIFF,
    OP_DIV100,
    OP_ERR,
    OP_TERM_P,
    OP_TERM_I,
    OP_TERM_D,
    OP_SAT,
    OP_DIV50,
    OP_EMIT
  } mpp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIV255,
    ST_DIFF,
    ST_DIV100,
    ST_ERR,
    ST_TERM_P,
    ST_TERM_I,
    ST_TERM_D,
    ST_SAT,
    ST_DIV50,
    ST_EMIT
  } mpp_state_t;

  typedef struct packed {
    logic    load;
    mpp_op_t op;
  } mpp_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } mpp_stat_t;

endpackage

### src/mpp_cfg.sv
module mpp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [mpp_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [mpp_pkg::CFG_DATA_W-1:0]  wr_data,
  output mpp_pkg::mpp_cfg_t               cfg
);
  import mpp_pkg::*;

  mpp_cfg_t cfg_r;
  mpp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_MIN_POSITION: cfg_nxt.min_position = wr_data;
        CFG_MAX_POSITION: cfg_nxt.max_position = wr_data;
        CFG_GAIN_P:       cfg_nxt.gain_p       = wr_data[GAIN_W-1:0];
        CFG_GAIN_I:       cfg_nxt.gain_i       = wr_data[GAIN_W-1:0];
        CFG_GAIN_D:       cfg_nxt.gain_d       = wr_data[GAIN_W-1:0];
        CFG_SPEED_LIMIT:  cfg_nxt.speed_limit  = wr_data[SPEED_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_position <= RST_MIN_POSITION;
      cfg_r.max_position <= RST_MAX_POSITION;
      cfg_r.gain_p       <= RST_GAIN_P;
      cfg_r.gain_i       <= RST_GAIN_I;
      cfg_r.gain_d       <= RST_GAIN_D;
      cfg_r.speed_limit  <= RST_SPEED_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/mpp_ctrl.sv
module mpp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpp_pkg::mpp_stat_t stat,
  output mpp_pkg::mpp_cmd_t  cmd
);
  import mpp_pkg::*;

  mpp_state_t state_r;
  mpp_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SPAN;
      ST_SPAN:   state_nxt = ST_DIV255;
      ST_DIV255: state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_DIV100;
      ST_DIV100: state_nxt = ST_ERR;
      ST_ERR:    state_nxt = ST_TERM_P;
      ST_TERM_P: state_nxt = ST_TERM_I;
      ST_TERM_I: state_nxt = ST_TERM_D;
      ST_TERM_D: state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_DIV50;
      ST_DIV50:  state_nxt = ST_EMIT;
      ST_EMIT:   if (!stat.out_blocked) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SPAN:   cmd.op = OP_SPAN;
      ST_DIV255: cmd.op = OP_DIV255;
      ST_DIFF:   cmd.op = OP_DIFF;
      ST_DIV100: cmd.op = OP_DIV100;
      ST_ERR:    cmd.op = OP_ERR;
      ST_TERM_P: cmd.op = OP_TERM_P;
      ST_TERM_I: cmd.op = OP_TERM_I;
      ST_TERM_D: cmd.op = OP_TERM_D;
      ST_SAT:    cmd.op = OP_SAT;
      ST_DIV50:  cmd.op = OP_DIV50;
      ST_EMIT:   if (!stat.out_blocked) cmd.op = OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/mpp_dp.sv
module mpp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpp_pkg::mpp_cmd_t             cmd,
  output mpp_pkg::mpp_stat_t            stat,
  input  mpp_pkg::mpp_cfg_t             cfg,
  input  logic [mpp_pkg::SLIDER_W-1:0]  in_slider,
  input  logic [mpp_pkg::POS_W-1:0]     in_encoder_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_move_right,
  output logic [mpp_pkg::SPEED_W-1:0]   out_speed
);
  import mpp_pkg::*;

  // Item registers
  logic [SLIDER_W-1:0]       slider_r;
  logic [POS_W-1:0]          pos_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      neg_r;
  logic [POS_W-1:0]          absv_r;
  logic signed [POS_W-1:0]   err_r;
  logic signed [ACC_W-1:0]   acc_r;

  // Loop state
  logic signed [POS_W-1:0]   error_sum_r;
  logic signed [POS_W-1:0]   last_error_r;

  // Result register
  logic                      out_valid_r;
  logic                      out_move_right_r;
  logic [SPEED_W-1:0]        out_speed_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic [POS_W-1:0]          span;
  logic [23:0]               div_in;
  logic [POS_W-1:0]          offset;
  logic [POS_W-1:0]          diff;
  logic [8:0]                q100;
  logic signed [POS_W-1:0]   err_val;
  logic signed [POS_W:0]     dterm;
  logic signed [POS_W-1:0]   sat_val;
  logic [9:0]                q50;
  logic [SPEED_W-1:0]        mag;

  assign span    = (cfg.max_position >= cfg.min_position) ?
                   cfg.max_position - cfg.min_position : '0;
  assign div_in  = prod_r[23:0] + CEIL_BIAS_255;
  assign offset  = prod_r[47:32];
  assign diff    = cfg.max_position - offset - pos_r;
  assign q100    = prod_r[31:23];
  assign err_val = neg_r ? -$signed({7'b0, q100}) : $signed({7'b0, q100});
  assign dterm   = {err_r[POS_W-1], err_r} - {last_error_r[POS_W-1], last_error_r};
  assign q50     = prod_r[31:22];
  assign mag     = (q50 > {2'b0, cfg.speed_limit}) ? cfg.speed_limit : q50[SPEED_W-1:0];

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat_val = 16'sh7fff;
    end else if (acc_r < SAT_LO) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = acc_r[POS_W-1:0];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SPAN: begin
        mul_a = {{(MUL_A_W-POS_W){1'b0}}, span};
        mul_b = {{(MUL_B_W-SLIDER_W){1'b0}}, slider_r};
      end
      OP_DIV255: begin
        mul_a = {{(MUL_A_W-24){1'b0}}, div_in};
        mul_b = RECIP_255;
      end
      OP_DIV100, OP_DIV50: begin
        mul_a = {{(MUL_A_W-POS_W){1'b0}}, absv_r};
        mul_b = RECIP_100_50;
      end
      OP_TERM_P: begin
        mul_a = {{(MUL_A_W-POS_W){err_r[POS_W-1]}}, err_r};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_p};
      end
      OP_TERM_I: begin
        mul_a = {{(MUL_A_W-POS_W){error_sum_r[POS_W-1]}}, error_sum_r};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_i};
      end
      OP_TERM_D: begin
        mul_a = {{(MUL_A_W-POS_W-1){dterm[POS_W]}}, dterm};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_d};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slider_r <= in_slider;
      pos_r    <= in_encoder_position;
    end
    unique case (cmd.op)
      OP_SPAN, OP_DIV255, OP_DIV100, OP_DIV50: prod_r <= mul_p[PROD_W-1:0];
      OP_DIFF: begin
        neg_r  <= diff[POS_W-1];
        absv_r <= diff[POS_W-1] ? -diff : diff;
      end
      OP_ERR:    err_r <= err_val;
      OP_TERM_P: acc_r <= mul_p[ACC_W-1:0];
      OP_TERM_I, OP_TERM_D: acc_r <= acc_r + $signed(mul_p[ACC_W-1:0]);
      OP_SAT: begin
        neg_r  <= sat_val[POS_W-1];
        absv_r <= sat_val[POS_W-1] ? -sat_val : sat_val;
      end
      OP_EMIT: begin
        out_move_right_r <= neg_r;
        out_speed_r      <= mag;
      end
      default: ;
    endcase
  end

  // Loop state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.op == OP_ERR) begin
        error_sum_r <= error_sum_r + err_val;
      end
      if (cmd.op == OP_TERM_D) begin
        last_error_r <= err_r;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_blocked = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_move_right   = out_move_right_r;
  assign out_speed        = out_speed_r;

endmodule

### src/motor_position_pid.sv
// Items are accepted only while the controller is idle, so one item is processed at a time;
// all products go through one shared multiplier stepped by the controller
// (span, three reciprocal divides, three gain terms).
// The result register lets the next item start while a result waits to be taken.
// Reset (rst_n low, synchronous): registers return to their default gains and limits,
// the integral and previous error clear, and no result is pending.
module motor_position_pid (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mpp_pkg::SLIDER_W-1:0]    in_slider,
  input  logic [mpp_pkg::POS_W-1:0]       in_encoder_position,
  // Result item channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_move_right,
  output logic [mpp_pkg::SPEED_W-1:0]     out_speed,
  // Register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mpp_pkg::*;

  mpp_cfg_t  cfg;
  mpp_cmd_t  cmd;
  mpp_stat_t stat;

  // Registers take a write every cycle; the user must write them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  mpp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Sequence each item through the steps:
  // span*slider, ceil divide by 255, error difference, divide by 100,
  // integral update, P/I/D multiply-accumulate, saturate, divide by 50, emit.
  mpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the item, the shared multiplier, the accumulator, loop state
  // and the result register.
  mpp_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg                 (cfg),
    .in_slider           (in_slider),
    .in_encoder_position (in_encoder_position),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_move_right      (out_move_right),
    .out_speed           (out_speed)
  );

endmodule
